>>> hdl/beam_rigid_body_mode_vectors_assert.svh
// ============================================================================
// Assertion macros for the beam rigid-body mode block
// Implication checks, removed when NO_ASSERTIONS is defined.
// ============================================================================
`ifndef BEAM_RIGID_BODY_MODE_VECTORS_ASSERT_SVH
`define BEAM_RIGID_BODY_MODE_VECTORS_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BRBM_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("brbm: implication check failed");
// next-cycle implication
`define BRBM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("brbm: next-cycle check failed");
`else
`define BRBM_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define BRBM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

>>> hdl/brbm_pkg.sv
// ============================================================================
// brbm_pkg
// Widths, transfer types and rounding helper for the beam rigid-body modes.
// ============================================================================
package brbm_pkg;

    localparam int COORD_W     = 32;                  // Q16.16 word
    localparam int FRAC_BITS   = 16;
    localparam int DIFF_W      = COORD_W + 1;         // exact difference
    localparam int NORM_W      = 31;                  // normalized magnitude
    localparam int NORM_MSB    = NORM_W - 1;
    localparam int POS_W       = $clog2(DIFF_W);
    localparam int SQ_W        = 2 * NORM_W;
    localparam int SUM_W       = 2 * NORM_W + 2;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int QUO_W       = FRAC_BITS + 2;
    localparam int NUM_W       = NORM_W + FRAC_BITS + 1;
    localparam int TAN_W       = QUO_W + 1;
    localparam int RND_W       = 2 * COORD_W + 2;
    localparam int SQRT_STEPS  = 2;
    localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;
    localparam int DIV_STEPS   = 2;
    localparam int DIV_STAGES  = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int APB_DW      = 32;
    localparam int ADDR_W      = 4;

    localparam logic [RND_W-1:0] RND_HALF    = RND_W'(1) << (FRAC_BITS - 1);
    localparam logic [RND_W-1:0] SAT_POS_MAG = (RND_W'(1) << (COORD_W - 1)) - RND_W'(1);
    localparam logic [RND_W-1:0] SAT_NEG_MAG = RND_W'(1) << (COORD_W - 1);
    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] node_x;
        logic signed [COORD_W-1:0] node_y;
        logic signed [COORD_W-1:0] node_z;
        logic signed [COORD_W-1:0] end_a_x;
        logic signed [COORD_W-1:0] end_a_y;
        logic signed [COORD_W-1:0] end_a_z;
        logic signed [COORD_W-1:0] end_b_x;
        logic signed [COORD_W-1:0] end_b_y;
        logic signed [COORD_W-1:0] end_b_z;
    } node_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] rot_one_x;
        logic signed [COORD_W-1:0] rot_one_y;
        logic signed [COORD_W-1:0] rot_one_z;
        logic signed [COORD_W-1:0] rot_two_x;
        logic signed [COORD_W-1:0] rot_two_y;
        logic signed [COORD_W-1:0] rot_two_z;
        logic signed [COORD_W-1:0] tang_one_x;
        logic signed [COORD_W-1:0] tang_one_y;
        logic signed [COORD_W-1:0] tang_one_z;
        logic signed [COORD_W-1:0] tang_two_x;
        logic signed [COORD_W-1:0] tang_two_y;
        logic signed [COORD_W-1:0] tang_two_z;
    } mode_t;

    // drop FRAC_BITS fraction bits, nearest with ties away from zero, saturate
    function automatic logic signed [COORD_W-1:0] round_sat(
        input logic signed [RND_W-1:0] val
    );
        logic [RND_W-1:0] mag_v;
        logic [RND_W-1:0] rnd_v;
        logic [RND_W-1:0] neg_v;
        logic signed [COORD_W-1:0] res;
        mag_v = val[RND_W-1] ? RND_W'(-val) : RND_W'(val);
        rnd_v = (mag_v + RND_HALF) >> FRAC_BITS;
        neg_v = -rnd_v;
        if (!val[RND_W-1])
        begin
            res = (rnd_v > SAT_POS_MAG) ? COORD_MAX : rnd_v[COORD_W-1:0];
        end
        else
        begin
            res = (rnd_v > SAT_NEG_MAG) ? COORD_MIN : neg_v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> hdl/brbm_delay.sv
// ============================================================================
// brbm_delay
// Stall-aware delay line that keeps side data aligned with a pipelined unit.
// ============================================================================
module brbm_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             adv,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);
    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];
endmodule

>>> hdl/brbm_sqrt.sv
// ============================================================================
// brbm_sqrt
// Pipelined integer square root, SQRT_STEPS result bits per stage.
// ============================================================================
module brbm_sqrt (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [brbm_pkg::SUM_W-1:0]  radicand,
    output logic [brbm_pkg::ROOT_W-1:0] root
);
    import brbm_pkg::*;

    logic [SUM_W-1:0] rem_reg [SQRT_STAGES];
    logic [SUM_W-1:0] acc_reg [SQRT_STAGES];

    for (genvar g = 0; g < SQRT_STAGES; g++)
    begin : g_stage
        logic [SUM_W-1:0] rem_in;
        logic [SUM_W-1:0] acc_in;
        logic [SUM_W-1:0] rem_next;
        logic [SUM_W-1:0] acc_next;

        if (g == 0)
        begin : g_first
            assign rem_in = radicand;
            assign acc_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign acc_in = acc_reg[g-1];
        end

        always_comb
        begin
            logic [SUM_W-1:0] rem_v;
            logic [SUM_W-1:0] acc_v;
            logic [SUM_W-1:0] bit_v;
            logic [SUM_W:0]   trial;
            rem_v = rem_in;
            acc_v = acc_in;
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                bit_v = SUM_W'(1) << (SUM_W - 2 - 2 * (g * SQRT_STEPS + k));
                trial = {1'b0, acc_v} + {1'b0, bit_v};
                if ({1'b0, rem_v} >= trial)
                begin
                    rem_v = rem_v - trial[SUM_W-1:0];
                    acc_v = (acc_v >> 1) + bit_v;
                end
                else
                begin
                    acc_v = acc_v >> 1;
                end
            end
            rem_next = rem_v;
            acc_next = acc_v;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[g] <= rem_next;
                acc_reg[g] <= acc_next;
            end
        end
    end

    assign root = acc_reg[SQRT_STAGES-1][ROOT_W-1:0];
endmodule

>>> hdl/brbm_div.sv
// ============================================================================
// brbm_div
// Pipelined restoring divider, DIV_STEPS quotient bits per stage.
// ============================================================================
module brbm_div (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [brbm_pkg::NUM_W-1:0]  numer,
    input  logic [brbm_pkg::ROOT_W-1:0] denom,
    output logic [brbm_pkg::QUO_W-1:0]  quot
);
    import brbm_pkg::*;

    localparam int DIVW = ROOT_W + QUO_W;

    logic [DIVW-1:0]   rem_reg [DIV_STAGES];
    logic [ROOT_W-1:0] den_reg [DIV_STAGES];
    logic [QUO_W-1:0]  quo_reg [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        logic [DIVW-1:0]   rem_in;
        logic [ROOT_W-1:0] den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [DIVW-1:0]   rem_next;
        logic [QUO_W-1:0]  quo_next;

        if (g == 0)
        begin : g_first
            assign rem_in = DIVW'(numer);
            assign den_in = denom;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign den_in = den_reg[g-1];
            assign quo_in = quo_reg[g-1];
        end

        always_comb
        begin
            logic [DIVW-1:0]  rem_v;
            logic [QUO_W-1:0] quo_v;
            logic [DIVW-1:0]  trial;
            rem_v = rem_in;
            quo_v = quo_in;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                if (g * DIV_STEPS + k < QUO_W)
                begin
                    trial = DIVW'(den_in) << (QUO_W - 1 - (g * DIV_STEPS + k));
                    if (rem_v >= trial)
                    begin
                        rem_v = rem_v - trial;
                        quo_v = {quo_v[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_v = {quo_v[QUO_W-2:0], 1'b0};
                    end
                end
            end
            rem_next = rem_v;
            quo_next = quo_v;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[g] <= rem_next;
                den_reg[g] <= den_in;
                quo_reg[g] <= quo_next;
            end
        end
    end

    assign quot = quo_reg[DIV_STAGES-1];
endmodule

>>> hdl/brbm_cross.sv
// ============================================================================
// brbm_cross
// Two-stage fixed-point cross product: products, then difference and rounding.
// ============================================================================
module brbm_cross #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic                                clk,
    input  logic                                adv,
    input  logic signed [A_W-1:0]               a_x,
    input  logic signed [A_W-1:0]               a_y,
    input  logic signed [A_W-1:0]               a_z,
    input  logic signed [B_W-1:0]               b_x,
    input  logic signed [B_W-1:0]               b_y,
    input  logic signed [B_W-1:0]               b_z,
    output logic signed [brbm_pkg::COORD_W-1:0] c_x,
    output logic signed [brbm_pkg::COORD_W-1:0] c_y,
    output logic signed [brbm_pkg::COORD_W-1:0] c_z
);
    import brbm_pkg::*;

    localparam int PROD_W = A_W + B_W;

    logic signed [PROD_W-1:0]  prod_reg [6];
    logic signed [COORD_W-1:0] c_x_reg;
    logic signed [COORD_W-1:0] c_y_reg;
    logic signed [COORD_W-1:0] c_z_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg[0] <= a_y * b_z;
            prod_reg[1] <= a_z * b_y;
            prod_reg[2] <= a_z * b_x;
            prod_reg[3] <= a_x * b_z;
            prod_reg[4] <= a_x * b_y;
            prod_reg[5] <= a_y * b_x;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_x_reg <= round_sat(RND_W'(prod_reg[0]) - RND_W'(prod_reg[1]));
            c_y_reg <= round_sat(RND_W'(prod_reg[2]) - RND_W'(prod_reg[3]));
            c_z_reg <= round_sat(RND_W'(prod_reg[4]) - RND_W'(prod_reg[5]));
        end
    end

    assign c_x = c_x_reg;
    assign c_y = c_y_reg;
    assign c_z = c_z_reg;
endmodule

>>> hdl/beam_rigid_body_mode_vectors.sv
// ============================================================================
// beam_rigid_body_mode_vectors
// Rotational rigid-body mode vectors of a straight beam node, pipelined.
// ============================================================================
// Node channel: node_valid/node_stall/node_data carry one node position and
// the two end nodes of its element; a transfer happens when valid is high
// and stall is low. Mode channel: mode_valid/mode_stall/mode_data return the
// four rotation columns (omega1/omega2 cross offset and cross tangent).
// Throughput is one node per cycle unless mode_stall holds the pipeline. From
// transfer to mode_valid the stages are: 5 setup stages, 16 square-root
// stages (2 root bits each), one numerator stage, 9 divider stages (2
// quotient bits each), the tangent and axis stage, the omega2 cross product,
// the final cross products and the output register.
// The whole pipeline advances together; while mode_valid is high and
// mode_stall is high, everything holds and node_stall is raised, so no
// transfer is lost or repeated. Reset clears the valid bits and zeroes the
// origin registers. The user sets the origin over APB (x, y, z at 0x0, 0x4,
// 0x8) only while the pipeline is empty; the block does not enforce this.
// ============================================================================
module beam_rigid_body_mode_vectors (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [brbm_pkg::ADDR_W-1:0] paddr,
    input  logic [brbm_pkg::APB_DW-1:0] pwdata,
    output logic [brbm_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    input  logic                        node_valid,
    output logic                        node_stall,
    input  brbm_pkg::node_t             node_data,
    output logic                        mode_valid,
    input  logic                        mode_stall,
    output brbm_pkg::mode_t             mode_data
);
    import brbm_pkg::*;

    `include "beam_rigid_body_mode_vectors_assert.svh"

    localparam int LAT = 12 + SQRT_STAGES + DIV_STAGES;

    localparam logic [1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] REG_ORIGIN_Z = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // side data riding along the root, divider and omega2 cross-product pipelines
    typedef struct packed {
        logic [2:0][NORM_W-1:0] norm;
        logic [2:0]             neg;
        logic [2:0][DIFF_W-1:0] off;
        logic                   zero;
    } sq_side_t;

    typedef struct packed {
        logic [2:0]             neg;
        logic [2:0][DIFF_W-1:0] off;
        logic                   zero;
    } dv_side_t;

    typedef struct packed {
        logic [2:0][TAN_W-1:0]   tan;
        logic [2:0][COORD_W-1:0] w1;
        logic [2:0][DIFF_W-1:0]  off;
        logic                    zero;
    } w_side_t;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    logic signed [COORD_W-1:0] origin_z_reg;
    logic [1:0]                reg_idx;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_ORIGIN_X: origin_x_reg <= pwdata[COORD_W-1:0];
                REG_ORIGIN_Y: origin_y_reg <= pwdata[COORD_W-1:0];
                REG_ORIGIN_Z: origin_z_reg <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ORIGIN_X: prdata = APB_DW'(origin_x_reg);
            REG_ORIGIN_Y: prdata = APB_DW'(origin_y_reg);
            REG_ORIGIN_Z: prdata = APB_DW'(origin_z_reg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // global advance and valid chain
    // ------------------------------------------------------------------
    logic           adv;
    logic [LAT-1:0] vld_reg;

    assign adv        = !(mode_valid && mode_stall);
    assign node_stall = !adv;
    assign mode_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], node_valid};
        end
    end

    // ------------------------------------------------------------------
    // S1: tangent difference and node offset, exact
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] d_x, d_y, d_z;
    logic [2:0][DIFF_W-1:0]   s1_mag_reg;
    logic [2:0]               s1_neg_reg;
    logic [2:0][DIFF_W-1:0]   s1_off_reg;

    assign d_x = DIFF_W'(node_data.end_b_x) - DIFF_W'(node_data.end_a_x);
    assign d_y = DIFF_W'(node_data.end_b_y) - DIFF_W'(node_data.end_a_y);
    assign d_z = DIFF_W'(node_data.end_b_z) - DIFF_W'(node_data.end_a_z);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mag_reg[0] <= d_x[DIFF_W-1] ? DIFF_W'(-d_x) : DIFF_W'(d_x);
            s1_mag_reg[1] <= d_y[DIFF_W-1] ? DIFF_W'(-d_y) : DIFF_W'(d_y);
            s1_mag_reg[2] <= d_z[DIFF_W-1] ? DIFF_W'(-d_z) : DIFF_W'(d_z);
            s1_neg_reg    <= {d_z[DIFF_W-1], d_y[DIFF_W-1], d_x[DIFF_W-1]};
            s1_off_reg[0] <= DIFF_W'(node_data.node_x) - DIFF_W'(origin_x_reg);
            s1_off_reg[1] <= DIFF_W'(node_data.node_y) - DIFF_W'(origin_y_reg);
            s1_off_reg[2] <= DIFF_W'(node_data.node_z) - DIFF_W'(origin_z_reg);
        end
    end

    // ------------------------------------------------------------------
    // S2: largest magnitude
    // ------------------------------------------------------------------
    logic [DIFF_W-1:0]      s2_max_reg;
    logic [2:0][DIFF_W-1:0] s2_mag_reg;
    logic [2:0]             s2_neg_reg;
    logic [2:0][DIFF_W-1:0] s2_off_reg;
    logic [DIFF_W-1:0]      max_xy;

    assign max_xy = (s1_mag_reg[1] > s1_mag_reg[0]) ? s1_mag_reg[1] : s1_mag_reg[0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_max_reg <= (s1_mag_reg[2] > max_xy) ? s1_mag_reg[2] : max_xy;
            s2_mag_reg <= s1_mag_reg;
            s2_neg_reg <= s1_neg_reg;
            s2_off_reg <= s1_off_reg;
        end
    end

    // ------------------------------------------------------------------
    // S3: shift all three so the largest lands in [2^30, 2^31)
    // ------------------------------------------------------------------
    logic [POS_W-1:0]       lead_pos;
    logic [2:0][NORM_W-1:0] norm_next;
    logic [2:0][NORM_W-1:0] s3_norm_reg;
    logic [2:0]             s3_neg_reg;
    logic [2:0][DIFF_W-1:0] s3_off_reg;
    logic                   s3_zero_reg;

    always_comb
    begin
        lead_pos = '0;
        for (int i = 0; i < DIFF_W; i++)
        begin
            if (s2_max_reg[i])
            begin
                lead_pos = POS_W'(i);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (lead_pos <= POS_W'(NORM_MSB))
            begin
                norm_next[i] = NORM_W'(s2_mag_reg[i] << (POS_W'(NORM_MSB) - lead_pos));
            end
            else
            begin
                norm_next[i] = NORM_W'(s2_mag_reg[i] >> (lead_pos - POS_W'(NORM_MSB)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_norm_reg <= norm_next;
            s3_neg_reg  <= s2_neg_reg;
            s3_off_reg  <= s2_off_reg;
            s3_zero_reg <= (s2_max_reg == '0);
        end
    end

    // ------------------------------------------------------------------
    // S4: squares; S5: sum of squares
    // ------------------------------------------------------------------
    logic [2:0][SQ_W-1:0] s4_sq_reg;
    sq_side_t             s4_side_reg;
    logic [SUM_W-1:0]     s5_sum_reg;
    sq_side_t             s5_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s4_sq_reg[i] <= SQ_W'(s3_norm_reg[i]) * SQ_W'(s3_norm_reg[i]);
            end
            s4_side_reg.norm <= s3_norm_reg;
            s4_side_reg.neg  <= s3_neg_reg;
            s4_side_reg.off  <= s3_off_reg;
            s4_side_reg.zero <= s3_zero_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_sum_reg  <= SUM_W'(s4_sq_reg[0]) + SUM_W'(s4_sq_reg[1]) + SUM_W'(s4_sq_reg[2]);
            s5_side_reg <= s4_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // length: pipelined square root
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0] root;
    sq_side_t          sq_side_out;

    brbm_sqrt u_sqrt (
        .clk      (clk),
        .adv      (adv),
        .radicand (s5_sum_reg),
        .root     (root)
    );

    brbm_delay #(
        .WIDTH ($bits(sq_side_t)),
        .DEPTH (SQRT_STAGES)
    ) u_sq_dly (
        .clk  (clk),
        .adv  (adv),
        .din  (s5_side_reg),
        .dout (sq_side_out)
    );

    // ------------------------------------------------------------------
    // S6: division numerators (rounded quotient)
    // ------------------------------------------------------------------
    logic [2:0][NUM_W-1:0] s6_num_reg;
    logic [ROOT_W-1:0]     s6_den_reg;
    dv_side_t              s6_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s6_num_reg[i] <= (NUM_W'(sq_side_out.norm[i]) << FRAC_BITS)
                               + NUM_W'(root >> 1);
            end
            s6_den_reg       <= root;
            s6_side_reg.neg  <= sq_side_out.neg;
            s6_side_reg.off  <= sq_side_out.off;
            s6_side_reg.zero <= sq_side_out.zero;
        end
    end

    // ------------------------------------------------------------------
    // unit tangent magnitudes: three pipelined dividers
    // ------------------------------------------------------------------
    logic [2:0][QUO_W-1:0] quot;
    dv_side_t              dv_side_out;

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        brbm_div u_div (
            .clk   (clk),
            .adv   (adv),
            .numer (s6_num_reg[c]),
            .denom (s6_den_reg),
            .quot  (quot[c])
        );
    end

    brbm_delay #(
        .WIDTH ($bits(dv_side_t)),
        .DEPTH (DIV_STAGES)
    ) u_dv_dly (
        .clk  (clk),
        .adv  (adv),
        .din  (s6_side_reg),
        .dout (dv_side_out)
    );

    // ------------------------------------------------------------------
    // S7: signed tangent, least-parallel axis, omega1 = t x axis
    // ------------------------------------------------------------------
    logic signed [TAN_W-1:0]   tan_v [3];
    logic signed [COORD_W-1:0] tan_w [3];
    logic [1:0]                axis;
    logic [2:0][COORD_W-1:0]   w1_next;
    w_side_t                   s7_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tan_v[i] = dv_side_out.neg[i] ? -TAN_W'(quot[i]) : TAN_W'(quot[i]);
            tan_w[i] = COORD_W'(tan_v[i]);
        end
        // smallest |t|, lower axis wins ties
        axis = AXIS_X;
        if (quot[1] < quot[0])
        begin
            axis = AXIS_Y;
        end
        if ((axis == AXIS_X && quot[2] < quot[0]) || (axis == AXIS_Y && quot[2] < quot[1]))
        begin
            axis = AXIS_Z;
        end
        unique case (axis)
            AXIS_X:
            begin
                w1_next[0] = '0;
                w1_next[1] = tan_w[2];
                w1_next[2] = -tan_w[1];
            end
            AXIS_Y:
            begin
                w1_next[0] = -tan_w[2];
                w1_next[1] = '0;
                w1_next[2] = tan_w[0];
            end
            AXIS_Z:
            begin
                w1_next[0] = tan_w[1];
                w1_next[1] = -tan_w[0];
                w1_next[2] = '0;
            end
            default:
            begin
                w1_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s7_side_reg.tan[i] <= tan_v[i];
            end
            s7_side_reg.w1   <= w1_next;
            s7_side_reg.off  <= dv_side_out.off;
            s7_side_reg.zero <= dv_side_out.zero;
        end
    end

    // ------------------------------------------------------------------
    // omega2 = t x omega1
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] w2_x, w2_y, w2_z;
    w_side_t                   w_side_out;

    brbm_cross #(
        .A_W (TAN_W),
        .B_W (COORD_W)
    ) u_cross_w2 (
        .clk (clk),
        .adv (adv),
        .a_x (s7_side_reg.tan[0]),
        .a_y (s7_side_reg.tan[1]),
        .a_z (s7_side_reg.tan[2]),
        .b_x (s7_side_reg.w1[0]),
        .b_y (s7_side_reg.w1[1]),
        .b_z (s7_side_reg.w1[2]),
        .c_x (w2_x),
        .c_y (w2_y),
        .c_z (w2_z)
    );

    brbm_delay #(
        .WIDTH ($bits(w_side_t)),
        .DEPTH (2)
    ) u_w_dly (
        .clk  (clk),
        .adv  (adv),
        .din  (s7_side_reg),
        .dout (w_side_out)
    );

    // ------------------------------------------------------------------
    // the four mode columns
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] r1_x, r1_y, r1_z;
    logic signed [COORD_W-1:0] r2_x, r2_y, r2_z;
    logic signed [COORD_W-1:0] q1_x, q1_y, q1_z;
    logic signed [COORD_W-1:0] q2_x, q2_y, q2_z;
    logic                      zero_out;

    brbm_cross #(
        .A_W (COORD_W),
        .B_W (DIFF_W)
    ) u_cross_r1 (
        .clk (clk),
        .adv (adv),
        .a_x (w_side_out.w1[0]),
        .a_y (w_side_out.w1[1]),
        .a_z (w_side_out.w1[2]),
        .b_x (w_side_out.off[0]),
        .b_y (w_side_out.off[1]),
        .b_z (w_side_out.off[2]),
        .c_x (r1_x),
        .c_y (r1_y),
        .c_z (r1_z)
    );

    brbm_cross #(
        .A_W (COORD_W),
        .B_W (DIFF_W)
    ) u_cross_r2 (
        .clk (clk),
        .adv (adv),
        .a_x (w2_x),
        .a_y (w2_y),
        .a_z (w2_z),
        .b_x (w_side_out.off[0]),
        .b_y (w_side_out.off[1]),
        .b_z (w_side_out.off[2]),
        .c_x (r2_x),
        .c_y (r2_y),
        .c_z (r2_z)
    );

    brbm_cross #(
        .A_W (COORD_W),
        .B_W (TAN_W)
    ) u_cross_q1 (
        .clk (clk),
        .adv (adv),
        .a_x (w_side_out.w1[0]),
        .a_y (w_side_out.w1[1]),
        .a_z (w_side_out.w1[2]),
        .b_x (w_side_out.tan[0]),
        .b_y (w_side_out.tan[1]),
        .b_z (w_side_out.tan[2]),
        .c_x (q1_x),
        .c_y (q1_y),
        .c_z (q1_z)
    );

    brbm_cross #(
        .A_W (COORD_W),
        .B_W (TAN_W)
    ) u_cross_q2 (
        .clk (clk),
        .adv (adv),
        .a_x (w2_x),
        .a_y (w2_y),
        .a_z (w2_z),
        .b_x (w_side_out.tan[0]),
        .b_y (w_side_out.tan[1]),
        .b_z (w_side_out.tan[2]),
        .c_x (q2_x),
        .c_y (q2_y),
        .c_z (q2_z)
    );

    brbm_delay #(
        .WIDTH (1),
        .DEPTH (2)
    ) u_zero_dly (
        .clk  (clk),
        .adv  (adv),
        .din  (w_side_out.zero),
        .dout (zero_out)
    );

    // ------------------------------------------------------------------
    // output register; a zero-length tangent gives an all-zero transfer
    // ------------------------------------------------------------------
    mode_t mode_data_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (zero_out)
            begin
                mode_data_reg <= '0;
            end
            else
            begin
                mode_data_reg.rot_one_x  <= r1_x;
                mode_data_reg.rot_one_y  <= r1_y;
                mode_data_reg.rot_one_z  <= r1_z;
                mode_data_reg.rot_two_x  <= r2_x;
                mode_data_reg.rot_two_y  <= r2_y;
                mode_data_reg.rot_two_z  <= r2_z;
                mode_data_reg.tang_one_x <= q1_x;
                mode_data_reg.tang_one_y <= q1_y;
                mode_data_reg.tang_one_z <= q1_z;
                mode_data_reg.tang_two_x <= q2_x;
                mode_data_reg.tang_two_y <= q2_y;
                mode_data_reg.tang_two_z <= q2_z;
            end
        end
    end

    assign mode_data = mode_data_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `BRBM_ASSERT_NEXT(a_in_lands, clk, rst_n, node_valid && !node_stall, vld_reg[0])
    `BRBM_ASSERT_NEXT(a_out_hold, clk, rst_n, mode_valid && mode_stall, mode_valid && $stable(mode_data))
    `BRBM_ASSERT_NEXT(a_drain, clk, rst_n, vld_reg[LAT-2] && !node_stall, mode_valid)
endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Beam rigid-body mode vector testbench
// Drives node transfers with random gaps and mode-side stalls, programs the
// rotation origin over APB between phases, and checks every mode transfer
// against a bit-accurate fixed-point predictor kept in a scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import brbm_pkg::*;

    localparam int  CLK_HALF     = 6;
    localparam int  IDLE_LIMIT   = 6000;  // cycles with no transfer and no APB access
    localparam int  DRAIN_CYCLES = 50;
    localparam int  HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int  RAND_ITEMS   = 830;

    localparam logic [ADDR_W-1:0] ORIGIN_X_ADDR = 4'h0;
    localparam logic [ADDR_W-1:0] ORIGIN_Y_ADDR = 4'h4;
    localparam logic [ADDR_W-1:0] ORIGIN_Z_ADDR = 4'h8;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the mode vectors of each accepted node and checks
    // mode transfers in order.
    // ------------------------------------------------------------------------
    class mode_scoreboard;
        mode_t  expected_modes[$];
        longint origin[3];
        int     mismatches;
        int     modes_checked;
        int     zero_tangents;

        function void clear_origin();
            origin = '{0, 0, 0};
        endfunction

        // drop FRAC_BITS fraction bits, ties away from zero, then saturate
        function longint round_q16(longint p);
            bit [63:0] m;
            longint    r;
            m = (p < 0) ? 64'(-p) : 64'(p);
            m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            r = longint'(m);
            if (p < 0)
                r = -r;
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            return r;
        endfunction

        function void cross_q16(input longint a[3], input longint b[3], output longint c[3]);
            c[0] = round_q16(a[1] * b[2] - a[2] * b[1]);
            c[1] = round_q16(a[2] * b[0] - a[0] * b[2]);
            c[2] = round_q16(a[0] * b[1] - a[1] * b[0]);
        endfunction

        function bit [63:0] floor_sqrt(bit [63:0] s);
            bit [63:0] r;
            bit [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > s)
                b >>= 2;
            while (b != 0)
            begin
                if (s >= r + b)
                begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function mode_t predict_modes(node_t nd);
            longint    d[3], tn[3], ax[3], w1[3], w2[3], off[3];
            longint    r1[3], r2[3], q1[3], q2[3];
            bit [63:0] m[3];
            bit [63:0] mx, n, q;
            int        k;
            mode_t     res;
            res = '0;
            d[0] = longint'(nd.end_b_x) - longint'(nd.end_a_x);
            d[1] = longint'(nd.end_b_y) - longint'(nd.end_a_y);
            d[2] = longint'(nd.end_b_z) - longint'(nd.end_a_z);
            for (int i = 0; i < 3; i++)
                m[i] = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
            mx = m[0];
            if (m[1] > mx) mx = m[1];
            if (m[2] > mx) mx = m[2];
            if (mx == 0)
            begin
                zero_tangents++;
                return res;
            end
            // normalize so the largest magnitude lies in [2^30, 2^31)
            while (mx < (64'd1 << 30))
            begin
                mx <<= 1;
                for (int i = 0; i < 3; i++) m[i] <<= 1;
            end
            while (mx >= (64'd1 << 31))
            begin
                mx >>= 1;
                for (int i = 0; i < 3; i++) m[i] >>= 1;
            end
            n = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
            for (int i = 0; i < 3; i++)
            begin
                q = ((m[i] << FRAC_BITS) + (n >> 1)) / n;
                tn[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
            end
            // least parallel axis, lowest index wins ties
            k = 0;
            for (int i = 1; i < 3; i++)
                if ((tn[i] < 0 ? -tn[i] : tn[i]) < (tn[k] < 0 ? -tn[k] : tn[k]))
                    k = i;
            ax = '{0, 0, 0};
            ax[k] = longint'(1) << FRAC_BITS;
            cross_q16(tn, ax, w1);
            cross_q16(tn, w1, w2);
            off[0] = longint'(nd.node_x) - origin[0];
            off[1] = longint'(nd.node_y) - origin[1];
            off[2] = longint'(nd.node_z) - origin[2];
            cross_q16(w1, off, r1);
            cross_q16(w2, off, r2);
            cross_q16(w1, tn, q1);
            cross_q16(w2, tn, q2);
            res.rot_one_x  = r1[0][31:0];
            res.rot_one_y  = r1[1][31:0];
            res.rot_one_z  = r1[2][31:0];
            res.rot_two_x  = r2[0][31:0];
            res.rot_two_y  = r2[1][31:0];
            res.rot_two_z  = r2[2][31:0];
            res.tang_one_x = q1[0][31:0];
            res.tang_one_y = q1[1][31:0];
            res.tang_one_z = q1[2][31:0];
            res.tang_two_x = q2[0][31:0];
            res.tang_two_y = q2[1][31:0];
            res.tang_two_z = q2[2][31:0];
            return res;
        endfunction

        function void note_node(node_t nd);
            expected_modes.push_back(predict_modes(nd));
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("MISMATCH %0t %s: got %h, expected %h", $time, what, got, want);
        endtask

        task check_mode(mode_t got);
            mode_t       want;
            logic [31:0] g, w;
            string       field_names[12];
            field_names = '{"rot_one_x", "rot_one_y", "rot_one_z",
                            "rot_two_x", "rot_two_y", "rot_two_z",
                            "tang_one_x", "tang_one_y", "tang_one_z",
                            "tang_two_x", "tang_two_y", "tang_two_z"};
            if (expected_modes.size() == 0)
            begin
                report_mismatch("unexpected mode transfer", 32'h0, 32'h0);
                return;
            end
            want = expected_modes.pop_front();
            modes_checked++;
            for (int i = 0; i < 12; i++)
            begin
                g = got[(11 - i) * COORD_W +: COORD_W];
                w = want[(11 - i) * COORD_W +: COORD_W];
                if (g !== w)
                    report_mismatch(field_names[i], g, w);
            end
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                node_valid;
    logic                node_stall;
    node_t               node_data;
    logic                mode_valid;
    logic                mode_stall;
    mode_t               mode_data;

    mode_scoreboard      sb;
    bit                  hold_request;   // asks the stall process for a long hold-off
    int                  nodes_sent;
    int                  phases_run;
    int                  idle_cycles;

    beam_rigid_body_mode_vectors u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .node_valid (node_valid),
        .node_stall (node_stall),
        .node_data  (node_data),
        .mode_valid (mode_valid),
        .mode_stall (mode_stall),
        .mode_data  (mode_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #CLK_HALF clk = ~clk;
    end

    // Monitors: note accepted nodes, check accepted modes.
    always @(posedge clk)
    begin
        if (rst_n && node_valid && !node_stall)
            sb.note_node(node_data);
        if (rst_n && mode_valid && !mode_stall)
            sb.check_mode(mode_data);
    end

    // Watchdog: any transfer or APB access resets the idle count.
    always @(posedge clk)
    begin
        if (!rst_n || (node_valid && !node_stall) || (mode_valid && !mode_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    // Short gaps mostly, an occasional long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Mode-side back-pressure, with runs of no stall and one long hold-off.
    initial
    begin
        int len;
        mode_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                mode_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if ($urandom_range(19) == 0)
            begin
                mode_stall <= 1'b0;
                repeat ($urandom_range(150, 50)) @(posedge clk);
            end
            else
            begin
                len = pick_gap();
                mode_stall <= ($urandom_range(9) < 3);
                repeat (len + 1) @(posedge clk);
            end
        end
    end

    // One node transfer after a random gap; valid stays high across
    // back-to-back transfers.
    task automatic send_node(node_t nd);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            node_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        node_valid <= 1'b1;
        node_data  <= nd;
        @(posedge clk);
        while (node_stall)
            @(posedge clk);
        nodes_sent++;
    endtask

    task automatic wait_drained();
        node_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_modes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Origin is only written with the pipeline empty.
    task automatic set_origin(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
        wait_drained();
        apb_write(ORIGIN_X_ADDR, ox);
        apb_write(ORIGIN_Y_ADDR, oy);
        apb_write(ORIGIN_Z_ADDR, oz);
        sb.origin[0] = longint'($signed(ox));
        sb.origin[1] = longint'($signed(oy));
        sb.origin[2] = longint'($signed(oz));
        phases_run++;
    endtask

    function automatic node_t make_node(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                                        logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                        logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
        return '{nx, ny, nz, ax, ay, az, bx, by, bz};
    endfunction

    function automatic logic [31:0] small_coord();
        return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
    endfunction

    // Random node: mostly a well-formed element, some axis-aligned or
    // degenerate, some fully random words.
    function automatic node_t random_node();
        int          kind;
        logic [31:0] ax, ay, az;
        logic [31:0] bx, by, bz;
        kind = $urandom_range(99);
        ax = small_coord();
        ay = small_coord();
        az = small_coord();
        bx = small_coord();
        by = small_coord();
        bz = small_coord();
        if (kind < 30)
            return make_node($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom);
        if (kind < 45)
        begin
            // axis-aligned tangent, random sign and axis
            bx = ax;
            by = ay;
            bz = az;
            case ($urandom_range(2))
                0: bx = ax + ($urandom_range(1) ? 32'd65536 : -32'd65536);
                1: by = ay + ($urandom_range(1) ? 32'd131072 : -32'd131072);
                default: bz = az + ($urandom_range(1) ? 32'd3 : -32'd3);
            endcase
        end
        else if (kind < 50)
        begin
            bx = ax;
            by = ay;
            bz = az;
        end
        return make_node(small_coord(), small_coord(), small_coord(), ax, ay, az, bx, by, bz);
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_node(random_node());
    endtask

    initial
    begin
        logic [31:0] mx, mn, one;
        sb = new();
        sb.clear_origin();
        mx  = 32'h7fff_ffff;
        mn  = 32'h8000_0000;
        one = 32'h0001_0000;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        node_valid   = 1'b0;
        node_data    = '0;
        hold_request = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed nodes at reset origin
        send_node(make_node(one, 0, 0, 0, 0, 0, 0, 0, 0));          // zero-length tangent
        send_node(make_node(mx, mn, 5, mx, mx, mx, mx, mx, mx));    // zero tangent, extremes
        send_node(make_node(one, one, one, 0, 0, 0, one, 0, 0));    // +x, tie on y/z
        send_node(make_node(one, one, one, one, 0, 0, 0, 0, 0));    // -x
        send_node(make_node(one, 0, one, 0, 0, 0, 0, -one, 0));     // -y, tie on x/z
        send_node(make_node(one, one, 0, 0, 0, 5, 0, 0, 0));        // -z, tie on x/y
        send_node(make_node(one, 0, 0, 0, 0, 0, one, one, one));    // three-way tie
        send_node(make_node(0, one, 0, 0, 0, 0, -one, -one, -one)); // negative three-way
        send_node(make_node(0, 0, 0, 0, 0, 0, one, one, 0));        // x/y tie, z smallest
        send_node(make_node(0, 0, 0, mn, mn, mn, mx, mx, mx));      // largest span
        send_node(make_node(0, 0, 0, mx, mx, mx, mn, mn, mn));      // largest negative span
        send_node(make_node(mx, mx, mx, mn, 0, 0, mx, 1, 0));       // large offsets
        send_node(make_node(mn, mn, mn, 0, 0, 0, 1, 0, 0));         // one-lsb tangent
        send_node(make_node(mx, mn, mx, 0, 0, 0, 0, 1, 1));
        send_node(make_node(32'h1234_5678, 32'h8765_4321, 32'hdead_beef,
                            0, 0, 0, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000));

        // Origin at the positive extreme: offsets reach the negative limit
        set_origin(mx, mx, mx);
        send_node(make_node(mn, mn, mn, 0, 0, 0, one, 0, 0));
        send_node(make_node(mn, mx, mn, 0, 0, 0, one, one, 0));
        run_random(RAND_ITEMS / 6);

        // Origin at the negative extreme, with a long receiver hold-off
        set_origin(mn, mn, mn);
        send_node(make_node(mx, mx, mx, 0, 0, 0, 0, 0, one));
        send_node(make_node(mx, mn, mx, 0, 0, 0, -one, 0, 0));
        hold_request = 1'b1;
        run_random(RAND_ITEMS / 6);

        // Sender pause until every expected mode has arrived
        wait_drained();
        run_random(RAND_ITEMS / 6);

        set_origin($urandom, $urandom, $urandom);
        run_random(RAND_ITEMS / 6);
        set_origin(small_coord(), small_coord(), small_coord());
        run_random(RAND_ITEMS / 6);
        set_origin(0, 0, 0);
        run_random(RAND_ITEMS - 5 * (RAND_ITEMS / 6));

        wait_drained();
        $display("covered %0d nodes (%0d zero-length) over %0d origin settings",
                 nodes_sent, sb.zero_tangents, phases_run + 1);
        $display("%0d mode transfers checked, %0d mismatches", sb.modes_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_modes.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
